>>> hw/rtl/nmea_gga_sentence_capture_unit_macros.svh
// Assertion macros shared by the checker of the GGA sentence capture unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef NMEA_GGA_SENTENCE_CAPTURE_UNIT_MACROS_SVH
`define NMEA_GGA_SENTENCE_CAPTURE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGGA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ngga: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NGGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ngga: next-cycle check failed");

`endif

>>> hw/rtl/ngga_pkg.sv
// Shared types, constants and helpers for the GGA sentence capture unit.
// No dependencies; the line controller, the top level and the port checker import this package.
package ngga_pkg;

  // Line capacity and derived widths.
  localparam int LINE_BYTES = 128;
  localparam int POS_W      = $clog2(LINE_BYTES + 1);
  localparam int IDX_W      = $clog2(LINE_BYTES);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 ** ADDR_W;

  // Fixed field widths.
  localparam int OPC_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int IN_IDX_W = 7;
  localparam int LEN_W    = 8;
  localparam int CMP_W    = (POS_W > IN_IDX_W) ? POS_W : IN_IDX_W;

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'd36;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
  localparam logic [BYTE_W-1:0] CH_A      = 8'd65;
  localparam logic [BYTE_W-1:0] CH_G      = 8'd71;

  typedef enum logic [OPC_W-1:0] {
    OP_RX    = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // What the line controller decides for one request.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_hit;
    logic              captured_now;
    logic              ready;
    logic [LEN_W-1:0]  length;
  } ngga_step_t;

  // Reported length saturates at the top of the output field.
  function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] len);
    logic [15:0] wide;
    wide = 16'(len);
    return (wide > 16'd255) ? 8'hFF : wide[LEN_W-1:0];
  endfunction

endpackage

>>> hw/rtl/ngga_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ngga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/ngga_line_ctrl.sv
// Line assembly and capture control for the GGA sentence capture unit.
// Depends on ngga_pkg; drives the sentence RAM through the step struct.
module ngga_line_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_fire,
  input  ngga_pkg::opcode_t              opcode,
  input  logic [ngga_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [ngga_pkg::IN_IDX_W-1:0]  read_index,
  output ngga_pkg::ngga_step_t           step
);
  import ngga_pkg::*;

  // Line state. The RAM holds two banks: the line being built and the
  // captured sentence. After a capture the line keeps appending into the
  // captured bank past its length; the next '$' moves the line to the other bank.
  logic [POS_W-1:0]  wp_r, wp_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic [BYTE_W-1:0] prev_byte_r, prev_byte_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ready_r, ready_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic              lbank_r, lbank_nxt;
  logic              cbank_r, cbank_nxt;
  logic              g3_r, g3_nxt;
  logic              g4_r, g4_nxt;
  logic              a5_r, a5_nxt;

  logic              is_rx;
  logic              is_dollar;
  logic              is_read;
  logic              is_clear;
  logic [POS_W-1:0]  wp_eff;
  logic              ovf_eff;
  logic              lbank_eff;
  logic              prev_ok;
  logic              room;
  logic              wr;
  logic              capture;
  logic [CMP_W-1:0]  idx_ext;

  assign is_rx     = req_fire && (opcode == OP_RX);
  assign is_read   = req_fire && (opcode == OP_READ);
  assign is_clear  = req_fire && (opcode == OP_CLEAR);
  assign is_dollar = is_rx && (rx_byte == CH_DOLLAR);

  // A '$' restarts the line before the byte is stored.
  assign wp_eff    = is_dollar ? '0 : wp_r;
  assign ovf_eff   = is_dollar ? 1'b0 : ovf_r;
  assign lbank_eff = is_dollar ? ~cbank_r : lbank_r;
  assign prev_ok   = !is_dollar && prev_valid_r && (prev_byte_r == CH_CR);

  // Store the byte while there is room, otherwise disqualify the line.
  assign room = wp_eff < POS_W'(LINE_BYTES);
  assign wr   = is_rx && room;

  always_comb begin
    wp_nxt  = wr ? (wp_eff + POS_W'(1)) : wp_eff;
    ovf_nxt = ovf_eff | (is_rx && !room);
    g3_nxt  = (wr && (wp_eff == POS_W'(3))) ? (rx_byte == CH_G) : g3_r;
    g4_nxt  = (wr && (wp_eff == POS_W'(4))) ? (rx_byte == CH_G) : g4_r;
    a5_nxt  = (wr && (wp_eff == POS_W'(5))) ? (rx_byte == CH_A) : a5_r;
  end

  // CR LF closes the line; the header check uses the latched match flags.
  assign capture = is_rx && (rx_byte == CH_LF) && prev_ok && !ovf_nxt &&
                   (wp_nxt >= POS_W'(6)) && g3_nxt && g4_nxt && a5_nxt;

  always_comb begin
    prev_valid_nxt = is_rx ? 1'b1 : prev_valid_r;
    prev_byte_nxt  = is_rx ? rx_byte : prev_byte_r;
    len_nxt        = capture ? wp_nxt : len_r;
    cbank_nxt      = capture ? lbank_eff : cbank_r;
    lbank_nxt      = lbank_eff;
    if (capture) begin
      ready_nxt = 1'b1;
    end else if (is_clear) begin
      ready_nxt = 1'b0;
    end else begin
      ready_nxt = ready_r;
    end
  end

  // Read range check against the length before this request.
  assign idx_ext = CMP_W'(read_index);

  always_comb begin
    step.wr_en        = wr;
    step.wr_addr      = {lbank_eff, wp_eff[IDX_W-1:0]};
    step.wr_data      = rx_byte;
    step.rd_en        = is_read;
    step.rd_addr      = {cbank_r, IDX_W'(read_index)};
    step.rd_hit       = is_read && (idx_ext < CMP_W'(len_r)) &&
                        (idx_ext < CMP_W'(LINE_BYTES));
    step.captured_now = capture;
    step.ready        = ready_nxt;
    step.length       = sat_len(len_nxt);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      prev_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
      ready_r      <= 1'b0;
      len_r        <= '0;
      lbank_r      <= 1'b0;
      cbank_r      <= 1'b0;
      g3_r         <= 1'b0;
      g4_r         <= 1'b0;
      a5_r         <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      prev_valid_r <= prev_valid_nxt;
      ovf_r        <= ovf_nxt;
      ready_r      <= ready_nxt;
      len_r        <= len_nxt;
      lbank_r      <= lbank_nxt;
      cbank_r      <= cbank_nxt;
      g3_r         <= g3_nxt;
      g4_r         <= g4_nxt;
      a5_r         <= a5_nxt;
    end
  end

  // Previous byte is payload, qualified by prev_valid_r.
  always_ff @(posedge clk) begin
    prev_byte_r <= prev_byte_nxt;
  end

endmodule

>>> hw/rtl/nmea_gga_sentence_capture_unit.sv
// Top level of the GGA sentence capture unit: handshake, result register, RAM.
// Depends on ngga_pkg, ngga_line_ctrl and ngga_ram.
//
//   Channel   Ports                                   Direction
//   in        in_valid/in_stall, opcode, byte, index  request in, one per cycle unless stalled
//   out       out_valid/out_stall, data, flags, len   one result per request
//
// The result appears in the cycle after acceptance.
// Throughput is one request per cycle while in_stall is low, set by the single RAM
// port pair (one write for a received byte, one read for a captured byte).
// Reset is synchronous and clears all control state; RAM contents need none.
// While a result waits under out_stall, in_stall is raised and no request enters.
module nmea_gga_sentence_capture_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ngga_pkg::OPC_W-1:0]     in_opcode,
  input  logic [ngga_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic [ngga_pkg::IN_IDX_W-1:0]  in_read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ngga_pkg::BYTE_W-1:0]    out_read_data,
  output logic                           out_captured_now,
  output logic                           out_sentence_ready,
  output logic [ngga_pkg::LEN_W-1:0]     out_captured_length
);
  import ngga_pkg::*;

  logic              req_fire;
  ngga_step_t        step;
  logic [BYTE_W-1:0] ram_rd_data;

  logic              out_valid_r, out_valid_nxt;
  logic              rd_hit_r;
  logic              captured_now_r;
  logic              ready_r;
  logic [LEN_W-1:0]  length_r;

  // A request enters whenever the result register is free or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign req_fire = in_valid && !in_stall;

  ngga_line_ctrl u_line_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (req_fire),
    .opcode     (opcode_t'(in_opcode)),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .step       (step)
  );

  // Both banks of sentence storage live in one RAM.
  ngga_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (step.wr_en),
    .wr_addr (step.wr_addr),
    .wr_data (step.wr_data),
    .rd_en   (step.rd_en),
    .rd_addr (step.rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result valid tracking.
  always_comb begin
    if (req_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; the RAM read data register holds alongside it.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_hit_r       <= step.rd_hit;
      captured_now_r <= step.captured_now;
      ready_r        <= step.ready;
      length_r       <= step.length;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = rd_hit_r ? ram_rd_data : '0;
  assign out_captured_now    = captured_now_r;
  assign out_sentence_ready  = ready_r;
  assign out_captured_length = length_r;

endmodule

>>> hw/rtl/ngga_port_checker.sv
// Port-level checks for the GGA sentence capture unit, bound to the top level.
// Depends on ngga_pkg and the shared assertion macros header.
`include "nmea_gga_sentence_capture_unit_macros.svh"

module ngga_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ngga_pkg::BYTE_W-1:0]    out_read_data,
  input logic                           out_captured_now,
  input logic                           out_sentence_ready,
  input logic [ngga_pkg::LEN_W-1:0]     out_captured_length
);
  import ngga_pkg::*;

  // Every accepted request yields a result in the following cycle.
  `NGGA_ASSERT_NEXT(a_req_gives_result, in_valid && !in_stall, out_valid)

  // A stalled result keeps its data.
  `NGGA_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
                    out_valid && $stable(out_read_data) && $stable(out_captured_length))

  // A capture always leaves the ready flag set.
  `NGGA_ASSERT_NOW(a_capture_sets_ready, out_valid && out_captured_now, out_sentence_ready)

  // A captured sentence holds at least the six header bytes.
  `NGGA_ASSERT_NOW(a_capture_length, out_valid && out_captured_now,
                   out_captured_length >= LEN_W'(6))

endmodule

bind nmea_gga_sentence_capture_unit ngga_port_checker u_ngga_port_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the GGA sentence capture unit: directed, stall and random requests.
// Depends on ngga_pkg and the nmea_gga_sentence_capture_unit RTL; needs no files or arguments.
module tb;
  import ngga_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASE_REQUESTS  = 250;

  // How a generated sentence is terminated.
  typedef enum int {
    END_CRLF,
    END_LF_ONLY,
    END_DOUBLE_CR,
    END_CR_GAP
  } line_end_t;

  // One expected response of the unit.
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              captured_now;
    logic              ready;
    logic [LEN_W-1:0]  length;
  } gga_result_t;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [OPC_W-1:0]    in_opcode     = OP_NOP;
  logic [BYTE_W-1:0]   in_rx_byte    = '0;
  logic [IN_IDX_W-1:0] in_read_index = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [BYTE_W-1:0]   out_read_data;
  logic                out_captured_now;
  logic                out_sentence_ready;
  logic [LEN_W-1:0]    out_captured_length;

  // Predicted state of the line assembler and the published sentence.
  logic [BYTE_W-1:0] line_mem [LINE_BYTES];
  logic [BYTE_W-1:0] sentence_mem [LINE_BYTES];
  int unsigned       line_pos     = 0;
  logic [8:0]        prev_rx      = '0;
  bit                line_over    = 1'b0;
  bit                ready_m      = 1'b0;
  int unsigned       sentence_len = 0;

  gga_result_t pending_results [$];
  gga_result_t head_result;
  int          mismatches    = 0;
  int          requests_sent = 0;
  int          cycle_count   = 0;
  int          send_gap_max  = 0;
  int          recv_gap_max  = 0;
  int          recv_wait     = 0;
  int          hold_left     = 0;

  nmea_gga_sentence_capture_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_rx_byte          (in_rx_byte),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_captured_now    (out_captured_now),
    .out_sentence_ready  (out_sentence_ready),
    .out_captured_length (out_captured_length)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the predicted state by one request and return its expected response.
  function automatic gga_result_t predict_gga(opcode_t op, logic [BYTE_W-1:0] rxb,
                                              logic [IN_IDX_W-1:0] idx);
    gga_result_t r;
    int unsigned k;
    r = '0;
    case (op)
      OP_RX: begin
        // A dollar sign restarts the line and forgets the previous byte.
        if (rxb == CH_DOLLAR) begin
          line_pos  = 0;
          prev_rx   = '0;
          line_over = 1'b0;
        end
        if (line_pos < LINE_BYTES) begin
          line_mem[line_pos] = rxb;
          line_pos++;
        end else begin
          line_over = 1'b1;
        end
        // CR LF closes the line; it is published only if it carries the GGA tag.
        if (rxb == CH_LF && prev_rx == {1'b1, CH_CR} && !line_over && line_pos >= 6 &&
            line_mem[3] == CH_G && line_mem[4] == CH_G && line_mem[5] == CH_A) begin
          for (k = 0; k < line_pos; k++) sentence_mem[k] = line_mem[k];
          sentence_len   = line_pos;
          ready_m        = 1'b1;
          r.captured_now = 1'b1;
        end
        prev_rx = {1'b1, rxb};
      end
      OP_READ: begin
        if (idx < sentence_len) r.read_data = sentence_mem[idx];
      end
      OP_CLEAR: begin
        ready_m = 1'b0;
      end
      OP_NOP: begin
      end
    endcase
    r.ready  = ready_m;
    r.length = (sentence_len > 255) ? 8'hFF : LEN_W'(sentence_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_v);
    mismatches++;
  endtask

  // Offer one request after a random gap and hold it until the unit takes it.
  task automatic send_request(opcode_t op, logic [BYTE_W-1:0] rxb,
                              logic [IN_IDX_W-1:0] idx);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_rx_byte    <= rxb;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_gga(op, rxb, idx));
    requests_sent++;
  endtask

  // Stop offering requests until every response has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_request(OP_RX, s[k], IN_IDX_W'($urandom));
    end
  endtask

  // Reads mostly fall at or below one past the published length so both sides of it are hit.
  task automatic send_read();
    int top;
    top = (sentence_len + 1 > 127) ? 127 : sentence_len + 1;
    if ($urandom_range(3, 0) == 0) top = 127;
    send_request(OP_READ, BYTE_W'($urandom), IN_IDX_W'($urandom_range(top, 0)));
  endtask

  // A dollar-led line with a talker id, a tag, a printable body and a chosen ending.
  task automatic send_sentence(int body_len, bit good_tag, line_end_t ending);
    logic [BYTE_W-1:0] line_q [$];
    logic [BYTE_W-1:0] ch;
    int k;
    line_q.push_back(CH_DOLLAR);
    line_q.push_back("G");
    line_q.push_back("P");
    if (good_tag) begin
      line_q.push_back(CH_G);
      line_q.push_back(CH_G);
      line_q.push_back(CH_A);
    end else begin
      repeat (3) line_q.push_back(BYTE_W'($urandom_range(90, 65)));
    end
    for (k = 0; k < body_len; k++) begin
      ch = BYTE_W'($urandom_range(126, 32));
      line_q.push_back((ch == CH_DOLLAR) ? ",": ch);
    end
    case (ending)
      END_CRLF: begin
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
      END_LF_ONLY: begin
        line_q.push_back(CH_LF);
      end
      END_DOUBLE_CR: begin
        line_q.push_back(CH_CR);
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
      END_CR_GAP: begin
        line_q.push_back(CH_CR);
        line_q.push_back("*");
        line_q.push_back(CH_LF);
      end
    endcase
    for (k = 0; k < line_q.size(); k++) begin
      // Reads in the middle of a line must not disturb its assembly.
      if ($urandom_range(99, 0) < 4) send_read();
      send_request(OP_RX, line_q[k], IN_IDX_W'($urandom));
    end
  endtask

  // Line edges right after reset, reads around the length, flag handling, extremes.
  task automatic test_line_edges();
    send_gap_max = 3;
    recv_gap_max = 3;
    // An LF with no byte before it closes nothing.
    send_request(OP_RX, CH_LF, '0);
    // The line started at reset carries GGA in positions 3 to 5 without a dollar.
    send_text("abGGA");
    send_request(OP_RX, CH_CR, '1);
    send_request(OP_RX, CH_LF, '0);
    send_request(OP_READ, '0, IN_IDX_W'(0));
    send_request(OP_READ, '1, IN_IDX_W'(7));
    send_request(OP_READ, '0, IN_IDX_W'(8));
    send_request(OP_READ, '0, IN_IDX_W'(127));
    send_request(OP_NOP, '1, '1);
    // The line keeps growing after a capture, and a second capture replaces the first.
    send_request(OP_RX, CH_CR, '0);
    send_request(OP_RX, CH_LF, '0);
    send_request(OP_CLEAR, '0, '0);
    // A short line is never published.
    send_text("$G");
    send_request(OP_RX, CH_CR, '0);
    send_request(OP_RX, CH_LF, '0);
    send_request(OP_RX, 8'hFF, '1);
    send_request(OP_RX, 8'h00, '0);
    send_request(OP_READ, '0, IN_IDX_W'(9));
    pause_until_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_left = 60;
    repeat (16) begin
      if ($urandom_range(1, 0) == 1) send_read();
      else send_request(OP_RX, BYTE_W'($urandom), IN_IDX_W'($urandom));
    end
    pause_until_drained();
  endtask

  // Sentences of exactly the line capacity, just past it and well past it.
  task automatic test_capacity();
    send_gap_max = 1;
    recv_gap_max = 1;
    send_sentence(LINE_BYTES - 8, 1'b1, END_CRLF);
    send_request(OP_READ, '0, IN_IDX_W'(127));
    send_sentence(LINE_BYTES - 7, 1'b1, END_CRLF);
    send_sentence(LINE_BYTES + 2, 1'b1, END_CRLF);
    send_request(OP_READ, '0, IN_IDX_W'(127));
    pause_until_drained();
  endtask

  // Mostly well-formed sentences with random content, mixed with reads, clears and noise.
  task automatic test_random_traffic();
    int stop_at;
    int next_phase;
    int phase;
    int pick;
    int body;
    line_end_t ending;
    stop_at    = requests_sent + RANDOM_REQUESTS;
    next_phase = requests_sent;
    phase      = 0;
    while (requests_sent < stop_at) begin
      // Rotate the idling pattern, waiting for all responses at each change.
      if (requests_sent >= next_phase) begin
        pause_until_drained();
        send_gap_max = (phase % 2 == 0) ? 19 : 0;
        recv_gap_max = ((phase / 2) % 2 == 0) ? 19 : 0;
        phase++;
        next_phase = requests_sent + PHASE_REQUESTS;
      end
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        body = $urandom_range(99, 0);
        if (body < 85) body = $urandom_range(12, 0);
        else if (body < 95) body = $urandom_range(60, 13);
        else body = $urandom_range(LINE_BYTES - 5, LINE_BYTES - 9);
        ending = ($urandom_range(1, 0) == 1) ? END_CRLF : line_end_t'($urandom_range(3, 0));
        send_sentence(body, $urandom_range(99, 0) < 85, ending);
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 1)) send_read();
      end else if (pick < 83) begin
        send_request(OP_CLEAR, BYTE_W'($urandom), IN_IDX_W'($urandom));
      end else if (pick < 88) begin
        send_request(OP_NOP, BYTE_W'($urandom), IN_IDX_W'($urandom));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_request(OP_RX, BYTE_W'($urandom), IN_IDX_W'($urandom));
        end
      end
    end
  endtask

  // Receiver stall: a long hold when asked, else the wait drawn for the next response.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response with no request waiting", 1, 0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_read_data !== head_result.read_data)
          report_mismatch("read_data", out_read_data, head_result.read_data);
        if (out_captured_now !== head_result.captured_now)
          report_mismatch("captured_now", out_captured_now, head_result.captured_now);
        if (out_sentence_ready !== head_result.ready)
          report_mismatch("sentence_ready", out_sentence_ready, head_result.ready);
        if (out_captured_length !== head_result.length)
          report_mismatch("captured_length", out_captured_length, head_result.length);
      end
      recv_wait = $urandom_range(recv_gap_max, 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_line_edges();
    test_backpressure();
    test_capacity();
    test_random_traffic();
    pause_until_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
